>>> rtl/core/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sync word frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Frame byte counter width; the counter saturates at its all-ones value
  localparam int COUNT_WIDTH   = 11;
  localparam int MIN_FRAME_LEN = 10;

  // Configuration register widths
  localparam int MAX_LEN_W = 11;
  localparam int SYNC_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;

  // Compare width: holds a frame length, the max length register and 13 + 255
  localparam int CMP_W = (COUNT_WIDTH + 1 > MAX_LEN_W) ? COUNT_WIDTH + 1 : MAX_LEN_W;

  // Frame layout
  localparam int SYNC_BYTES = 4;
  localparam int HDR_FIRST  = 4;
  localparam int HDR_BYTES  = 8;
  localparam int LEN_FIELD  = 6;
  localparam int CMD_FIELD  = 7;
  localparam int LEN_POS    = 10;
  localparam int PAY_POS    = 11;
  localparam int FIT_BASE   = LEN_POS + 3;

  // Register reset values
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(1024);
  localparam logic [SYNC_W-1:0]    SYNC_RESET    = 32'h55AA_CC33;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD     = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_SHORT     = 3'd2,
    ST_BAD_SYNC  = 3'd3,
    ST_BAD_CSUM  = 3'd4
  } status_t;

  // Classified byte as handed from front to back
  typedef struct packed {
    logic                          pay;
    logic [7:0]                    data;
    logic                          last;
    logic                          too_long;
    logic                          too_short;
    logic                          sync_ok;
    logic                          csum_ok;
    logic                          fit_ok;
    logic [HDR_BYTES-1:0][7:0]     hdr;
  } rec_t;

endpackage

>>> rtl/core/sfd_byte_if.sv
// ----------------------------------------------------------------------------
// sfd_byte_if
// Byte input channel: one raw frame byte per transaction.
// ----------------------------------------------------------------------------
interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_frame;

  modport source (output valid, in_byte, end_of_frame, input ready);
  modport sink   (input valid, in_byte, end_of_frame, output ready);
endinterface

>>> rtl/core/sfd_result_if.sv
// ----------------------------------------------------------------------------
// sfd_result_if
// Result channel: payload pass-through and end-of-frame report.
// ----------------------------------------------------------------------------
interface sfd_result_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       frame_done;
  logic [2:0] status;
  logic [7:0] can_channel;
  logic [7:0] rx_addr;
  logic [7:0] tx_addr;
  logic [7:0] loop_addr;
  logic [7:0] device_addr;
  logic [7:0] frame_kind;
  logic [7:0] payload_len;
  logic [7:0] command_code;

  modport source (output valid, payload_valid, payload_byte, frame_done, status,
                  can_channel, rx_addr, tx_addr, loop_addr, device_addr,
                  frame_kind, payload_len, command_code, input ready);
  modport sink   (input valid, payload_valid, payload_byte, frame_done, status,
                  can_channel, rx_addr, tx_addr, loop_addr, device_addr,
                  frame_kind, payload_len, command_code, output ready);
endinterface

>>> rtl/core/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Accepts frame bytes, tracks position, checksum, sync and header, and
// pushes a classified record for every byte that yields a result.
// ----------------------------------------------------------------------------
module sfd_front (
  input  logic                         clk,
  input  logic                         rst,
  sfd_byte_if.sink                     byte_ch,
  input  logic                         cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         q_full,
  output logic                         q_push,
  output sfd_pkg::rec_t                q_rec
);

  localparam int CW = sfd_pkg::COUNT_WIDTH;
  localparam int MW = sfd_pkg::CMP_W;

  logic [sfd_pkg::MAX_LEN_W-1:0] max_frame_len;
  logic [sfd_pkg::SYNC_W-1:0]    sync_word;

  logic [CW-1:0]  byte_count;
  logic           count_over;
  logic [15:0]    sum_acc;
  logic [7:0]     tail_bytes [2];
  logic [7:0]     hdr [sfd_pkg::HDR_BYTES];
  logic           sync_ok;

  logic [MW-1:0]  idx;
  logic [MW-1:0]  flen;
  logic [7:0]     b;
  logic           accept;
  logic           pay;
  logic           sync_next;
  logic [15:0]    sum_next;
  logic [15:0]    crc;
  logic [sfd_pkg::SYNC_W-1:0] sync_shift;
  logic [7:0]     hdr_next [sfd_pkg::HDR_BYTES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= sfd_pkg::MAX_LEN_RESET;
      sync_word     <= sfd_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::REG_MAX_FRAME_LEN: max_frame_len <= cfg_data[sfd_pkg::MAX_LEN_W-1:0];
        sfd_pkg::REG_SYNC_WORD:     sync_word     <= cfg_data[sfd_pkg::SYNC_W-1:0];
        default: ;
      endcase
    end
  end

  assign byte_ch.ready = !q_full;
  assign accept        = byte_ch.valid && byte_ch.ready;
  assign b             = byte_ch.in_byte;
  assign idx           = MW'(byte_count);
  assign flen          = idx + MW'(1);

  // Expected sync byte: position p takes bits 8*(3-p) upwards
  assign sync_shift = sync_word >> {~byte_count[1:0], 3'b000};

  always_comb begin
    sync_next = sync_ok;
    if (!count_over && idx < MW'(sfd_pkg::SYNC_BYTES) && b != sync_shift[7:0]) begin
      sync_next = 1'b0;
    end
  end

  // Header capture for the byte at hand
  always_comb begin
    for (int i = 0; i < sfd_pkg::HDR_BYTES; i++) begin
      hdr_next[i] = (!count_over && idx == MW'(sfd_pkg::HDR_FIRST + i)) ? b : hdr[i];
    end
  end

  // Payload position, against the declared length seen so far
  assign pay = !count_over && idx >= MW'(sfd_pkg::PAY_POS) &&
               (idx - MW'(sfd_pkg::PAY_POS)) < MW'(hdr[sfd_pkg::LEN_FIELD]);

  // Running sum lags two bytes so the trailing checksum stays out of it
  assign sum_next = (count_over || idx >= MW'(2)) ? sum_acc + 16'(tail_bytes[0]) : sum_acc;
  assign crc      = {b, tail_bytes[1]};

  // Record for the queue
  always_comb begin
    q_rec.pay       = pay;
    q_rec.data      = b;
    q_rec.last      = byte_ch.end_of_frame;
    q_rec.too_long  = count_over || flen > MW'(max_frame_len);
    q_rec.too_short = flen < MW'(sfd_pkg::MIN_FRAME_LEN);
    q_rec.sync_ok   = sync_next;
    q_rec.csum_ok   = crc == sum_next;
    q_rec.fit_ok    = flen >= MW'(sfd_pkg::FIT_BASE) &&
                      MW'(hdr_next[sfd_pkg::LEN_FIELD]) + MW'(sfd_pkg::FIT_BASE) <= flen;
    for (int i = 0; i < sfd_pkg::HDR_BYTES; i++) begin
      q_rec.hdr[i] = hdr_next[i];
    end
  end

  assign q_push = accept && (pay || byte_ch.end_of_frame);

  // Frame state; cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst || (accept && byte_ch.end_of_frame)) begin
      byte_count <= '0;
      count_over <= 1'b0;
      sum_acc    <= '0;
      tail_bytes <= '{default: '0};
      hdr        <= '{default: '0};
      sync_ok    <= 1'b1;
    end else if (accept) begin
      if (byte_count == {CW{1'b1}}) begin
        count_over <= 1'b1;
      end else begin
        byte_count <= byte_count + CW'(1);
      end
      sum_acc       <= sum_next;
      tail_bytes[0] <= tail_bytes[1];
      tail_bytes[1] <= b;
      hdr           <= hdr_next;
      sync_ok       <= sync_next;
    end
  end

endmodule

>>> rtl/core/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue
// Short record queue between front and back.
// ----------------------------------------------------------------------------
module sfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfd_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sfd_pkg::rec_t head_rec
);

  sfd_pkg::rec_t                entries [sfd_pkg::QUEUE_DEPTH];
  logic [sfd_pkg::QPTR_W-1:0]   wr_ptr;
  logic [sfd_pkg::QPTR_W-1:0]   rd_ptr;
  logic [sfd_pkg::QCNT_W-1:0]   fill;

  assign full       = fill == sfd_pkg::QCNT_W'(sfd_pkg::QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_rec   = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sfd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sfd_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + sfd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - sfd_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Resolves frame status by check priority, masks the report fields and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module sfd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  sfd_pkg::rec_t head_rec,
  output logic          pop,
  sfd_result_if.source  result_ch
);

  sfd_pkg::status_t status_next;
  logic             ok;
  logic             out_valid;
  logic             payload_valid;
  logic [7:0]       payload_byte;
  logic             frame_done;
  logic [2:0]       status;
  logic [7:0]       fields [7];
  logic [7:0]       command_code;

  // Check order: too long, short, sync, checksum, payload fit
  always_comb begin
    priority if (head_rec.too_long) begin
      status_next = sfd_pkg::ST_TOO_LONG;
    end else if (head_rec.too_short) begin
      status_next = sfd_pkg::ST_SHORT;
    end else if (!head_rec.sync_ok) begin
      status_next = sfd_pkg::ST_BAD_SYNC;
    end else if (!head_rec.csum_ok) begin
      status_next = sfd_pkg::ST_BAD_CSUM;
    end else if (!head_rec.fit_ok) begin
      status_next = sfd_pkg::ST_SHORT;
    end else begin
      status_next = sfd_pkg::ST_OK;
    end
  end

  assign ok  = head_rec.last && status_next == sfd_pkg::ST_OK;
  assign pop = head_valid && (!out_valid || result_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result_ch.ready) begin
      out_valid <= head_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      payload_valid <= head_rec.pay;
      payload_byte  <= head_rec.pay ? head_rec.data : 8'h00;
      frame_done    <= head_rec.last;
      status        <= head_rec.last ? 3'(status_next) : 3'(sfd_pkg::ST_OK);
      for (int i = 0; i < 7; i++) begin
        fields[i] <= ok ? head_rec.hdr[i] : 8'h00;
      end
      command_code  <= (ok && head_rec.hdr[sfd_pkg::LEN_FIELD] != 8'h00)
                       ? head_rec.hdr[sfd_pkg::CMD_FIELD] : 8'h00;
    end
  end

  assign result_ch.valid         = out_valid;
  assign result_ch.payload_valid = payload_valid;
  assign result_ch.payload_byte  = payload_byte;
  assign result_ch.frame_done    = frame_done;
  assign result_ch.status        = status;
  assign result_ch.can_channel   = fields[0];
  assign result_ch.rx_addr       = fields[1];
  assign result_ch.tx_addr       = fields[2];
  assign result_ch.loop_addr     = fields[3];
  assign result_ch.device_addr   = fields[4];
  assign result_ch.frame_kind    = fields[5];
  assign result_ch.payload_len   = fields[6];
  assign result_ch.command_code  = command_code;

endmodule

>>> rtl/core/sync_word_frame_deframer_top.sv
// Path: each result goes through the record queue, then the output register.
// Throughput: one byte per cycle; bytes that are neither payload nor last in the
// frame take no queue slot. Input stalls only once the two-entry queue is full.
// Reset (rst, synchronous): frame state cleared, queue and output empty,
// max_frame_len = 1024, sync_word = 0x55AACC33.
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_top
// Byte-wise frame deframer: sync, header capture, checksum and length
// checks, payload pass-through and end-of-frame report.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst,
  sfd_byte_if.sink                      byte_ch,
  sfd_result_if.source                  result_ch,
  input  logic                          cfg_we,
  input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfd_pkg::CFG_W-1:0]     cfg_data
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  sfd_pkg::rec_t push_rec;
  sfd_pkg::rec_t head_rec;

  sfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (push_rec)
  );

  sfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (head_rec)
  );

  sfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_rec   (head_rec),
    .pop        (q_pop),
    .result_ch  (result_ch)
  );

endmodule
